@@ hdl/cmoe_pkg.sv @@
// Package for the memory-operand ALU execute block: item types, operation codes
// and the per-operation cycle tables. No dependencies.
`default_nettype none

package cmoe_pkg;

  typedef struct packed {
    logic [4:0]  func;
    logic [7:0]  operand;
    logic [15:0] address;
    logic [2:0]  mode;
    logic        crossed_page;
    logic        to_accumulator;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  x_reg;
    logic [7:0]  y_reg;
    logic        carry;
    logic        zero;
    logic        negative;
    logic        overflow;
    logic        mem_write;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [3:0]  cycle_cost;
    logic        bad_mode;
  } out_item_t;

  localparam logic [4:0] F_ORA = 5'd0;
  localparam logic [4:0] F_AND = 5'd1;
  localparam logic [4:0] F_EOR = 5'd2;
  localparam logic [4:0] F_ADC = 5'd3;
  localparam logic [4:0] F_STA = 5'd4;
  localparam logic [4:0] F_LDA = 5'd5;
  localparam logic [4:0] F_CMP = 5'd6;
  localparam logic [4:0] F_SBC = 5'd7;
  localparam logic [4:0] F_ASL = 5'd8;
  localparam logic [4:0] F_ROL = 5'd9;
  localparam logic [4:0] F_LSR = 5'd10;
  localparam logic [4:0] F_ROR = 5'd11;
  localparam logic [4:0] F_STX = 5'd12;
  localparam logic [4:0] F_LDX = 5'd13;
  localparam logic [4:0] F_DEC = 5'd14;
  localparam logic [4:0] F_INC = 5'd15;
  localparam logic [4:0] F_BIT = 5'd16;
  localparam logic [4:0] F_STY = 5'd17;
  localparam logic [4:0] F_LDY = 5'd18;
  localparam logic [4:0] F_CPY = 5'd19;
  localparam logic [4:0] F_CPX = 5'd20;

  // Table entry that marks a mode the operation does not support.
  localparam logic [3:0] COST_BAD = 4'hF;

  typedef logic [3:0] cost_tab_t [8];

  localparam cost_tab_t CYC_ALU    = '{4'd6, 4'd3, 4'd2, 4'd4, 4'd5, 4'd4, 4'd4, 4'd4};
  localparam cost_tab_t CYC_STA    = '{4'd6, 4'd3, COST_BAD, 4'd4, 4'd6, 4'd4, 4'd5, 4'd5};
  localparam cost_tab_t CYC_SHIFT  = '{COST_BAD, 4'd5, 4'd2, 4'd6,
                                       COST_BAD, 4'd6, COST_BAD, 4'd7};
  localparam cost_tab_t CYC_LDXY   = '{4'd2, 4'd3, COST_BAD, 4'd4,
                                       COST_BAD, 4'd4, COST_BAD, 4'd4};
  localparam cost_tab_t CYC_INCDEC = '{COST_BAD, 4'd5, COST_BAD, 4'd6,
                                       COST_BAD, 4'd6, COST_BAD, 4'd7};
  localparam cost_tab_t CYC_BIT    = '{COST_BAD, 4'd3, COST_BAD, 4'd4,
                                       COST_BAD, COST_BAD, COST_BAD, COST_BAD};
  localparam cost_tab_t CYC_CPXY   = '{4'd2, 4'd3, COST_BAD, 4'd4,
                                       COST_BAD, COST_BAD, COST_BAD, COST_BAD};
  localparam cost_tab_t CYC_STXY   = '{COST_BAD, 4'd3, COST_BAD, 4'd4,
                                       COST_BAD, 4'd4, COST_BAD, COST_BAD};

  // Base cycle count for an operation in a mode, COST_BAD where there is none.
  function automatic logic [3:0] base_cost(input logic [4:0] func, input logic [2:0] mode);
    logic [3:0] c;
    c = COST_BAD;
    if (func <= F_SBC && func != F_STA) c = CYC_ALU[mode];
    else if (func == F_STA) c = CYC_STA[mode];
    else if (func <= F_ROR) c = CYC_SHIFT[mode];
    else if (func == F_STX || func == F_STY) c = CYC_STXY[mode];
    else if (func == F_LDX || func == F_LDY) c = CYC_LDXY[mode];
    else if (func == F_DEC || func == F_INC) c = CYC_INCDEC[mode];
    else if (func == F_BIT) c = CYC_BIT[mode];
    else if (func == F_CPY || func == F_CPX) c = CYC_CPXY[mode];
    return c;
  endfunction

  // ALU operations other than store, and the X and Y loads, add one to the cost on a page cross.
  function automatic logic reads_memory(input logic [4:0] func);
    return (func <= F_SBC && func != F_STA) || func == F_LDX || func == F_LDY;
  endfunction

endpackage

`default_nettype wire

@@ hdl/cpu_memory_operand_alu_execute.sv @@
// Top level of the memory-operand ALU execute block: input register, execute
// logic, architectural registers and result register. Uses cmoe_pkg.
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall   in_data  (in_item_t)
// out       output     out_valid / out_stall out_data (out_item_t)
//
// One item is taken per cycle while in_stall is low.
// The item sits in the input register while the execute logic works on it, and
// then moves into the result register once no stall on out holds the result.
// The register file and flags are updated when an item moves into the result register,
// so the next item sees them at once.
// Reset clears the registers, flags and both stages. A stall on out holds the
// result and, once both stages are full, raises in_stall.

module cpu_memory_operand_alu_execute
  import cmoe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic      in_full;
  in_item_t  in_q;
  logic      advance;

  logic [7:0] a, x, y;
  logic       c, z, n, v;

  logic [7:0] a_next, x_next, y_next;
  logic       c_next, z_next, n_next, v_next;
  logic       wr;
  logic [7:0] wdata;
  logic [3:0] cost;
  logic       bad;

  assign advance  = in_full && !(out_valid && out_stall);
  assign in_stall = in_full && out_valid && out_stall;

  always_comb begin
    logic [3:0] tab;
    logic [7:0] m, m_add, sh_in, sh_out, cmp_reg, r;
    logic [8:0] sum, diff;
    tab     = base_cost(in_q.func, in_q.mode);
    bad     = (tab == COST_BAD);
    cost    = bad ? 4'd0 : tab + {3'd0, reads_memory(in_q.func) & in_q.crossed_page};
    m       = in_q.operand;
    m_add   = (in_q.func == F_SBC) ? ~m : m;
    sum     = {1'b0, a} + {1'b0, m_add} + {8'd0, c};
    cmp_reg = (in_q.func == F_CPY) ? y : ((in_q.func == F_CPX) ? x : a);
    diff    = {1'b0, cmp_reg} - {1'b0, m};
    sh_in   = in_q.to_accumulator ? a : m;
    sh_out  = '0;
    unique case (in_q.func)
      F_ASL:   sh_out = {sh_in[6:0], 1'b0};
      F_ROL:   sh_out = {sh_in[6:0], c};
      F_LSR:   sh_out = {1'b0, sh_in[7:1]};
      default: sh_out = {c, sh_in[7:1]};
    endcase

    a_next = a; x_next = x; y_next = y;
    c_next = c; z_next = z; n_next = n; v_next = v;
    wr     = 1'b0;
    wdata  = '0;
    r      = '0;
    if (!bad) begin
      unique case (in_q.func)
        F_ORA: begin r = a | m; a_next = r; end
        F_AND: begin r = a & m; a_next = r; end
        F_EOR: begin r = a ^ m; a_next = r; end
        F_ADC, F_SBC: begin
          r      = sum[7:0];
          a_next = r;
          c_next = sum[8];
          v_next = (a[7] ^ r[7]) & (m_add[7] ^ r[7]);
        end
        F_STA: begin wr = 1'b1; wdata = a; end
        F_LDA: begin r = m; a_next = m; end
        F_CMP, F_CPX, F_CPY: begin
          r      = diff[7:0];
          c_next = !diff[8];
        end
        F_ASL, F_ROL: begin
          r      = sh_out;
          c_next = sh_in[7];
          if (in_q.to_accumulator) a_next = r;
          else begin wr = 1'b1; wdata = r; end
        end
        F_LSR, F_ROR: begin
          r      = sh_out;
          c_next = sh_in[0];
          if (in_q.to_accumulator) a_next = r;
          else begin wr = 1'b1; wdata = r; end
        end
        F_STX: begin wr = 1'b1; wdata = x; end
        F_LDX: begin r = m; x_next = m; end
        F_DEC: begin r = m - 8'd1; wr = 1'b1; wdata = r; end
        F_INC: begin r = m + 8'd1; wr = 1'b1; wdata = r; end
        F_STY: begin wr = 1'b1; wdata = y; end
        F_LDY: begin r = m; y_next = m; end
        default: r = '0;
      endcase
      // Stores leave the flags alone; bit test has flag rules of its own.
      if (in_q.func == F_BIT) begin
        z_next = ((a & m) == 8'd0);
        n_next = m[7];
        v_next = m[6];
      end else if (in_q.func != F_STA && in_q.func != F_STX && in_q.func != F_STY) begin
        z_next = (r == 8'd0);
        n_next = r[7];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
      a <= '0; x <= '0; y <= '0;
      c <= 1'b0; z <= 1'b0; n <= 1'b0; v <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_full <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        a <= a_next; x <= x_next; y <= y_next;
        c <= c_next; z <= z_next; n <= n_next; v <= v_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_q <= in_data;
    end
    if (advance) begin
      out_data.acc           <= a_next;
      out_data.x_reg         <= x_next;
      out_data.y_reg         <= y_next;
      out_data.carry         <= c_next;
      out_data.zero          <= z_next;
      out_data.negative      <= n_next;
      out_data.overflow      <= v_next;
      out_data.mem_write     <= wr;
      out_data.write_address <= in_q.address;
      out_data.write_data    <= wdata;
      out_data.cycle_cost    <= cost;
      out_data.bad_mode      <= bad;
    end
  end

endmodule

`default_nettype wire

@@ hdl/cmoe_checker.sv @@
// Port-level checks for the memory-operand ALU execute block, bound to its top
// level. Uses cmoe_pkg.
`default_nettype none

module cmoe_checker
  import cmoe_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // A result that waits must stay put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // A rejected instruction costs nothing and writes nothing.
  a_bad_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.bad_mode |-> out_data.cycle_cost == 4'd0 && !out_data.mem_write
      && out_data.write_data == 8'd0)
    else $error("bad mode item has cost or write");

  // Every supported instruction has a nonzero cost within the bounds checked here.
  a_cost_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.bad_mode |-> out_data.cycle_cost >= 4'd2
      && out_data.cycle_cost <= 4'd8)
    else $error("cycle cost out of range");

  // The input side only backs up when the result side is stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  // After reset no result is shown.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind cpu_memory_operand_alu_execute cmoe_checker u_cmoe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for cpu_memory_operand_alu_execute: a directed table, then random
// instructions, checked against written-out results or a bench model of registers and flags.
// Depends on cmoe_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_top
  import cmoe_pkg::*;
();

  // Operation codes past the last real instruction; the block must reject them.
  localparam logic [4:0] UNUSED_OP_FIRST = 5'd21;
  localparam logic [4:0] UNUSED_OP_LAST  = 5'd31;

  localparam int NO_MODE = -1;
  localparam int ALU_CYCLES[8]      = '{6, 3, 2, 4, 5, 4, 4, 4};
  localparam int STA_CYCLES[8]      = '{6, 3, NO_MODE, 4, 6, 4, 5, 5};
  localparam int SHIFT_CYCLES[8]    = '{NO_MODE, 5, 2, 6, NO_MODE, 6, NO_MODE, 7};
  localparam int LOAD_XY_CYCLES[8]  = '{2, 3, NO_MODE, 4, NO_MODE, 4, NO_MODE, 4};
  localparam int INC_DEC_CYCLES[8]  = '{NO_MODE, 5, NO_MODE, 6, NO_MODE, 6, NO_MODE, 7};
  localparam int BIT_CYCLES[8]      = '{NO_MODE, 3, NO_MODE, 4,
                                        NO_MODE, NO_MODE, NO_MODE, NO_MODE};
  localparam int CMP_XY_CYCLES[8]   = '{2, 3, NO_MODE, 4, NO_MODE, NO_MODE, NO_MODE, NO_MODE};
  localparam int STORE_XY_CYCLES[8] = '{NO_MODE, 3, NO_MODE, 4, NO_MODE, 4, NO_MODE, NO_MODE};

  typedef struct {
    in_item_t  stim;
    logic      typed;
    out_item_t result;
  } directed_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Architectural state as the block should hold it after every accepted item.
  logic [7:0] arch_acc = 8'h00;
  logic [7:0] arch_x   = 8'h00;
  logic [7:0] arch_y   = 8'h00;
  logic       flag_c = 1'b0;
  logic       flag_z = 1'b0;
  logic       flag_n = 1'b0;
  logic       flag_v = 1'b0;

  out_item_t     expected_results[$];
  directed_row_t directed_rows[$];
  int            failures = 0;
  int            rx_count = 0;
  int            rx_seen = 0;
  int            rx_hold = 0;
  bit            tx_quiet = 1'b0;
  bit            rx_quiet = 1'b0;

  cpu_memory_operand_alu_execute dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("cpu_memory_operand_alu_execute regression: fail");
    $finish;
  end

  function automatic int table_cycles(input logic [4:0] op, input logic [2:0] md);
    case (op)
      F_ORA, F_AND, F_EOR, F_ADC, F_LDA, F_CMP, F_SBC: return ALU_CYCLES[md];
      F_STA:                      return STA_CYCLES[md];
      F_ASL, F_ROL, F_LSR, F_ROR: return SHIFT_CYCLES[md];
      F_STX, F_STY:               return STORE_XY_CYCLES[md];
      F_LDX, F_LDY:               return LOAD_XY_CYCLES[md];
      F_DEC, F_INC:               return INC_DEC_CYCLES[md];
      F_BIT:                      return BIT_CYCLES[md];
      F_CPX, F_CPY:               return CMP_XY_CYCLES[md];
      default:                    return NO_MODE;
    endcase
  endfunction

  function automatic void set_zn(input logic [7:0] v);
    flag_z = (v == 8'h00);
    flag_n = v[7];
  endfunction

  function automatic void compare_with(input logic [7:0] lhs, input logic [7:0] m);
    flag_c = (lhs >= m);
    set_zn(lhs - m);
  endfunction

  // Executes one instruction on the bench copy of the state and returns the result item.
  function automatic out_item_t execute_instruction(input in_item_t it);
    out_item_t  r;
    int         cost;
    logic [7:0] src;
    logic [7:0] res;
    logic [7:0] addend;
    logic [8:0] sum;
    r = '0;
    cost = table_cycles(it.func, it.mode);
    if (cost != NO_MODE) begin
      if (it.func inside {F_ORA, F_AND, F_EOR, F_ADC, F_LDA, F_CMP, F_SBC, F_LDX, F_LDY})
        cost += it.crossed_page;
      case (it.func)
        F_ORA: begin arch_acc = arch_acc | it.operand; set_zn(arch_acc); end
        F_AND: begin arch_acc = arch_acc & it.operand; set_zn(arch_acc); end
        F_EOR: begin arch_acc = arch_acc ^ it.operand; set_zn(arch_acc); end
        F_ADC, F_SBC: begin
          // Subtract is add of the inverted operand, carry set meaning no borrow.
          addend = (it.func == F_SBC) ? ~it.operand : it.operand;
          sum = {1'b0, arch_acc} + {1'b0, addend} + {8'd0, flag_c};
          flag_v = (arch_acc[7] ^ sum[7]) & (addend[7] ^ sum[7]);
          flag_c = sum[8];
          arch_acc = sum[7:0];
          set_zn(arch_acc);
        end
        F_STA: begin r.mem_write = 1'b1; r.write_data = arch_acc; end
        F_LDA: begin arch_acc = it.operand; set_zn(it.operand); end
        F_CMP: compare_with(arch_acc, it.operand);
        F_ASL, F_ROL, F_LSR, F_ROR: begin
          src = it.to_accumulator ? arch_acc : it.operand;
          if (it.func == F_ASL || it.func == F_ROL) begin
            res = {src[6:0], (it.func == F_ROL) & flag_c};
            flag_c = src[7];
          end else begin
            res = {(it.func == F_ROR) & flag_c, src[7:1]};
            flag_c = src[0];
          end
          set_zn(res);
          if (it.to_accumulator) begin
            arch_acc = res;
          end else begin
            r.mem_write = 1'b1;
            r.write_data = res;
          end
        end
        F_STX: begin r.mem_write = 1'b1; r.write_data = arch_x; end
        F_LDX: begin arch_x = it.operand; set_zn(it.operand); end
        F_DEC, F_INC: begin
          res = (it.func == F_DEC) ? it.operand - 8'd1 : it.operand + 8'd1;
          r.mem_write = 1'b1;
          r.write_data = res;
          set_zn(res);
        end
        F_BIT: begin
          flag_z = ((arch_acc & it.operand) == 8'h00);
          flag_n = it.operand[7];
          flag_v = it.operand[6];
        end
        F_STY: begin r.mem_write = 1'b1; r.write_data = arch_y; end
        F_LDY: begin arch_y = it.operand; set_zn(it.operand); end
        F_CPY: compare_with(arch_y, it.operand);
        default: compare_with(arch_x, it.operand);
      endcase
    end
    r.acc = arch_acc;
    r.x_reg = arch_x;
    r.y_reg = arch_y;
    r.carry = flag_c;
    r.zero = flag_z;
    r.negative = flag_n;
    r.overflow = flag_v;
    r.write_address = it.address;
    r.cycle_cost = (cost == NO_MODE) ? 4'd0 : 4'(cost);
    r.bad_mode = (cost == NO_MODE);
    return r;
  endfunction

  function automatic in_item_t instr(input logic [4:0] op, input logic [7:0] m,
                                     input logic [15:0] addr, input logic [2:0] md,
                                     input logic pc, input logic ta);
    in_item_t it;
    it.func = op;
    it.operand = m;
    it.address = addr;
    it.mode = md;
    it.crossed_page = pc;
    it.to_accumulator = ta;
    return it;
  endfunction

  function automatic string describe(input out_item_t o);
    return $sformatf("A=%h X=%h Y=%h CZNV=%b%b%b%b wr=%b addr=%h data=%h cost=%0d bad=%b",
                     o.acc, o.x_reg, o.y_reg, o.carry, o.zero, o.negative, o.overflow,
                     o.mem_write, o.write_address, o.write_data, o.cycle_cost, o.bad_mode);
  endfunction

  // Valid stays high from one item to the next unless a gap is drawn.
  task automatic send_item(input in_item_t it, input logic use_typed, input out_item_t typed);
    int        gap;
    out_item_t predicted;
    gap = tx_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = execute_instruction(it);
    expected_results.push_back(use_typed ? typed : predicted);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_results.size() != 0);
  endtask

  // Receiver: after each accepted item it may hold stall high for a drawn number of cycles.
  initial begin
    forever begin
      @(negedge clk);
      if (rx_count != rx_seen) begin
        rx_seen = rx_count;
        rx_hold = rx_quiet ? 0 : $urandom_range(0, 14);
      end
      out_stall <= (rx_hold > 0);
      if (rx_hold > 0) rx_hold--;
    end
  end

  always @(posedge clk) begin
    string     diff;
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result item: %s", describe(out_data));
      end else begin
        want = expected_results.pop_front();
        diff = "";
        if (out_data.acc !== want.acc) diff = {diff, " acc"};
        if (out_data.x_reg !== want.x_reg) diff = {diff, " x_reg"};
        if (out_data.y_reg !== want.y_reg) diff = {diff, " y_reg"};
        if (out_data.carry !== want.carry) diff = {diff, " carry"};
        if (out_data.zero !== want.zero) diff = {diff, " zero"};
        if (out_data.negative !== want.negative) diff = {diff, " negative"};
        if (out_data.overflow !== want.overflow) diff = {diff, " overflow"};
        if (out_data.mem_write !== want.mem_write) diff = {diff, " mem_write"};
        if (out_data.write_address !== want.write_address) diff = {diff, " write_address"};
        if (out_data.write_data !== want.write_data) diff = {diff, " write_data"};
        if (out_data.cycle_cost !== want.cycle_cost) diff = {diff, " cycle_cost"};
        if (out_data.bad_mode !== want.bad_mode) diff = {diff, " bad_mode"};
        if (diff != "") begin
          failures++;
          if (failures <= 10) begin
            $display("mismatch in%s", diff);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(out_data));
          end
        end
      end
      rx_count++;
    end
  end

  initial begin
    logic [4:0]  op;
    logic [2:0]  md;
    logic [7:0]  m;
    int          n;
    logic [7:0]  corner_bytes[4];
    corner_bytes = '{8'h00, 8'hFF, 8'h80, 8'h7F};

    // The first three rows follow on from the reset state, so their results are written out.
    directed_rows = '{
      '{instr(UNUSED_OP_LAST, 8'hFF, 16'hFFFF, 3'd7, 1'b1, 1'b1), 1'b1,
        {8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'hFFFF, 8'h00, 4'd0, 1'b1}},
      '{instr(F_LDA, 8'h80, 16'h1234, 3'd2, 1'b1, 1'b0), 1'b1,
        {8'h80, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'h1234, 8'h00, 4'd3, 1'b0}},
      '{instr(F_ADC, 8'h80, 16'h0000, 3'd2, 1'b0, 1'b0), 1'b1,
        {8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 16'h0000, 8'h00, 4'd2, 1'b0}},
      '{instr(F_SBC, 8'h00, 16'hFFFF, 3'd1, 1'b1, 1'b0), 1'b0, '0},
      '{instr(F_STA, 8'h55, 16'h00FF, 3'd2, 1'b0, 1'b0), 1'b0, '0},
      '{instr(F_STA, 8'hAA, 16'hFF00, 3'd4, 1'b1, 1'b0), 1'b0, '0},
      '{instr(F_ORA, 8'hFF, 16'h8000, 3'd4, 1'b1, 1'b0), 1'b0, '0},
      '{instr(F_AND, 8'h7F, 16'h0001, 3'd6, 1'b0, 1'b0), 1'b0, '0},
      '{instr(F_EOR, 8'hFF, 16'h7FFF, 3'd7, 1'b1, 1'b0), 1'b0, '0},
      '{instr(F_CMP, 8'h80, 16'h2000, 3'd0, 1'b0, 1'b0), 1'b0, '0},
      '{instr(F_ASL, 8'h00, 16'h3000, 3'd2, 1'b0, 1'b1), 1'b0, '0},
      '{instr(F_ROL, 8'h81, 16'h3001, 3'd1, 1'b0, 1'b0), 1'b0, '0},
      '{instr(F_LSR, 8'hFF, 16'h3002, 3'd2, 1'b0, 1'b1), 1'b0, '0},
      '{instr(F_ROR, 8'h01, 16'h3003, 3'd7, 1'b1, 1'b0), 1'b0, '0},
      // Accumulator shift in a memory mode still shifts the accumulator.
      '{instr(F_ASL, 8'h00, 16'h3004, 3'd3, 1'b0, 1'b1), 1'b0, '0},
      '{instr(F_STX, 8'h00, 16'h4000, 3'd1, 1'b0, 1'b0), 1'b0, '0},
      '{instr(F_LDX, 8'hFF, 16'h4001, 3'd0, 1'b1, 1'b0), 1'b0, '0},
      '{instr(F_DEC, 8'h00, 16'h4002, 3'd3, 1'b0, 1'b0), 1'b0, '0},
      '{instr(F_INC, 8'hFF, 16'h4003, 3'd5, 1'b1, 1'b0), 1'b0, '0},
      '{instr(F_BIT, 8'hC0, 16'h4004, 3'd1, 1'b0, 1'b0), 1'b0, '0},
      '{instr(F_STY, 8'h00, 16'h4005, 3'd5, 1'b0, 1'b0), 1'b0, '0},
      '{instr(F_LDY, 8'h00, 16'h4006, 3'd3, 1'b1, 1'b0), 1'b0, '0},
      '{instr(F_CPY, 8'h01, 16'h4007, 3'd0, 1'b0, 1'b0), 1'b0, '0},
      '{instr(F_CPX, 8'h00, 16'h4008, 3'd0, 1'b0, 1'b0), 1'b0, '0},
      // The accumulator flag means nothing to an add.
      '{instr(F_ADC, 8'h7F, 16'h4009, 3'd5, 1'b0, 1'b1), 1'b0, '0},
      '{instr(UNUSED_OP_FIRST, 8'h12, 16'h400A, 3'd1, 1'b0, 1'b0), 1'b0, '0}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].result);
    drain_results();

    n = 0;
    while (n < 870) begin
      if (n % 60 == 0) begin
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      if (n == 450) drain_results();
      if ($urandom_range(0, 15) == 0)
        op = 5'($urandom_range(UNUSED_OP_FIRST, UNUSED_OP_LAST));
      else
        op = 5'($urandom_range(F_ORA, F_CPX));
      md = 3'($urandom_range(0, 7));
      // Most items use a mode the operation supports; the rest draw any mode and may exercise rejection.
      if (op <= F_CPX && $urandom_range(0, 3) != 0)
        while (table_cycles(op, md) == NO_MODE) md = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 3) == 0)
        m = corner_bytes[$urandom_range(0, 3)];
      else
        m = 8'($urandom_range(0, 255));
      send_item(instr(op, m, 16'($urandom_range(0, 65535)), md, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1))), 1'b0, '0);
      n++;
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0)
      $display("cpu_memory_operand_alu_execute regression: pass");
    else
      $display("cpu_memory_operand_alu_execute regression: fail");
    $finish;
  end

endmodule
